// File: hw/rtl/nmea_sentence_framer_xor_check_defines.svh
// Assertion macros for the NMEA sentence framer.
`ifndef NMEA_SENTENCE_FRAMER_XOR_CHECK_DEFINES_SVH
`define NMEA_SENTENCE_FRAMER_XOR_CHECK_DEFINES_SVH

`ifndef SYNTHESIS

`define NSF_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

`define NSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define NSF_ASSERT_ALWAYS(label, expr, msg)

`define NSF_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: hw/rtl/nsf_pkg.sv
// Shared types, constants and helpers for the NMEA sentence framer.
package nsf_pkg;

    localparam int unsigned MAX_FRAME_LEN = 128;

    localparam logic [31:0] TAG_RESET         = 32'h5047414D;
    localparam logic [3:0]  FIELD_COUNT_RESET = 4'd14;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [0:0] CFG_TAG         = 1'b0;
    localparam logic [0:0] CFG_FIELD_COUNT = 1'b1;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TAG       = 3'd1;
    localparam logic [2:0] ERR_DELIM     = 3'd2;
    localparam logic [2:0] ERR_CHECKSUM  = 3'd3;
    localparam logic [2:0] ERR_NO_CR     = 3'd4;
    localparam logic [2:0] ERR_NO_LF     = 3'd5;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd6;
    localparam logic [2:0] ERR_RESTARTED = 3'd7;

    typedef struct packed {
        logic [7:0] echo_byte;
        logic [3:0] field_number;
        logic       in_field;
        logic       frame_end;
        logic       frame_good;
        logic [2:0] error_code;
    } t_result;

    // {bad, value}: bad is set for anything but 0-9 or A-F
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, c[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/nmea_sentence_framer_xor_check.sv
// Top level of the NMEA sentence framer with XOR checksum check.
//
//  channel   handshake            payload
//  ------    ---------            -------
//  input     i_valid / o_ready    i_in_byte
//  result    o_valid / i_ready    o_echo_byte .. o_error_code
//  config    i_cfg_we             i_cfg_index, i_cfg_data
//
// One request per cycle sustained while i_ready holds; each passes the input register, then the result register.
// Parser state advances only when a character moves into the result register.
// A stalled consumer backs up the two registers, then drops o_ready.
// Synchronous active-low reset restores default tag and field count and idles the parser.
module nmea_sentence_framer_xor_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_echo_byte,
    output logic [3:0]  o_field_number,
    output logic        o_in_field,
    output logic        o_frame_end,
    output logic        o_frame_good,
    output logic [2:0]  o_error_code,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import nsf_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_ready;
    logic       fire;
    t_result    parse_res;
    t_result    out_res;

    assign fire = in_valid && out_ready;

    nsf_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_byte  (i_in_byte),
        .i_take  (out_ready),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    nsf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_byte      (in_byte),
        .o_res       (parse_res)
    );

    nsf_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_ready (out_ready),
        .i_res   (parse_res),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    assign o_echo_byte    = out_res.echo_byte;
    assign o_field_number = out_res.field_number;
    assign o_in_field     = out_res.in_field;
    assign o_frame_end    = out_res.frame_end;
    assign o_frame_good   = out_res.frame_good;
    assign o_error_code   = out_res.error_code;

endmodule

// File: hw/rtl/nsf_in_reg.sv
// Input register: holds one received character until the parser takes it.
module nsf_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    import nsf_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

// File: hw/rtl/nsf_parser.sv
// Sentence parser: configuration, framing state and per-character result logic.
module nsf_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_fire,
    input  logic [7:0]            i_byte,
    output nsf_pkg::t_result      o_res
);
    import nsf_pkg::*;

    `include "nmea_sentence_framer_xor_check_defines.svh"

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_TAG    = 3'd1;
    localparam logic [2:0] PH_FIELDS = 3'd2;
    localparam logic [2:0] PH_HEX1   = 3'd3;
    localparam logic [2:0] PH_HEX2   = 3'd4;
    localparam logic [2:0] PH_CR     = 3'd5;
    localparam logic [2:0] PH_LF     = 3'd6;

    localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME_LEN);

    logic [31:0] r_tag;
    logic [3:0]  r_field_count;

    logic [2:0] r_phase,  n_phase;
    logic [2:0] r_tag_pos, n_tag_pos;
    logic [3:0] r_dcnt,   n_dcnt;
    logic [7:0] r_len,    n_len;
    logic [7:0] r_xor,    n_xor;
    logic [3:0] r_hi,     n_hi;

    logic [4:0] nfields;
    logic [4:0] dcnt_inc;
    logic [7:0] want;
    logic [4:0] hex;
    logic       abort;
    t_result    res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag         <= TAG_RESET;
            r_field_count <= FIELD_COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TAG:         r_tag         <= i_cfg_data;
                CFG_FIELD_COUNT: r_field_count <= i_cfg_data[3:0];
                default:         r_tag         <= r_tag;
            endcase
        end
    end

    assign nfields  = (r_field_count == 4'd0) ? 5'd1 : {1'b0, r_field_count};
    assign dcnt_inc = {1'b0, r_dcnt} + 5'd1;
    assign hex      = hex_decode(i_byte);

    always_comb begin
        unique case (r_tag_pos[1:0])
            2'd0:    want = r_tag[31:24];
            2'd1:    want = r_tag[23:16];
            2'd2:    want = r_tag[15:8];
            default: want = r_tag[7:0];
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_tag_pos = r_tag_pos;
        n_dcnt    = r_dcnt;
        n_len     = r_len;
        n_xor     = r_xor;
        n_hi      = r_hi;
        abort     = 1'b0;

        res.echo_byte    = i_byte;
        res.field_number = 4'd0;
        res.in_field     = 1'b0;
        res.frame_end    = 1'b0;
        res.frame_good   = 1'b0;
        res.error_code   = ERR_NONE;

        if (i_byte == CH_DOLLAR) begin
            if (r_phase != PH_IDLE) begin
                res.frame_end  = 1'b1;
                res.error_code = ERR_RESTARTED;
            end
            n_phase   = PH_TAG;
            n_tag_pos = 3'd0;
            n_dcnt    = 4'd0;
            n_len     = 8'd1;
            n_xor     = 8'd0;
            n_hi      = 4'd0;
        end else if (r_phase != PH_IDLE && r_len >= MAX_LEN) begin
            res.frame_end  = 1'b1;
            res.error_code = ERR_TOO_LONG;
            abort          = 1'b1;
        end else begin
            if (r_phase != PH_IDLE) begin
                n_len = r_len + 8'd1;
            end
            unique case (r_phase)
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                PH_TAG: begin
                    if (r_tag_pos < 3'd4) begin
                        if (i_byte == want) begin
                            n_xor     = r_xor ^ i_byte;
                            n_tag_pos = r_tag_pos + 3'd1;
                        end else begin
                            res.frame_end  = 1'b1;
                            res.error_code = ERR_TAG;
                            abort          = 1'b1;
                        end
                    end else if (i_byte == CH_COMMA) begin
                        n_xor   = r_xor ^ i_byte;
                        n_dcnt  = 4'd0;
                        n_phase = PH_FIELDS;
                    end else begin
                        res.frame_end  = 1'b1;
                        res.error_code = ERR_DELIM;
                        abort          = 1'b1;
                    end
                end
                PH_FIELDS: begin
                    res.field_number = r_dcnt;
                    if (i_byte == CH_COMMA) begin
                        if (dcnt_inc < nfields) begin
                            n_xor  = r_xor ^ i_byte;
                            n_dcnt = r_dcnt + 4'd1;
                        end else begin
                            res.frame_end  = 1'b1;
                            res.error_code = ERR_DELIM;
                            abort          = 1'b1;
                        end
                    end else if (i_byte == CH_STAR) begin
                        if (dcnt_inc == nfields) begin
                            n_phase = PH_HEX1;
                        end else begin
                            res.frame_end  = 1'b1;
                            res.error_code = ERR_DELIM;
                            abort          = 1'b1;
                        end
                    end else begin
                        res.in_field = 1'b1;
                        n_xor        = r_xor ^ i_byte;
                    end
                end
                PH_HEX1: begin
                    if (!hex[4]) begin
                        n_hi    = hex[3:0];
                        n_phase = PH_HEX2;
                    end else begin
                        res.frame_end  = 1'b1;
                        res.error_code = ERR_DELIM;
                        abort          = 1'b1;
                    end
                end
                PH_HEX2: begin
                    if (hex[4]) begin
                        res.frame_end  = 1'b1;
                        res.error_code = ERR_DELIM;
                        abort          = 1'b1;
                    end else if ({r_hi, hex[3:0]} != r_xor) begin
                        res.frame_end  = 1'b1;
                        res.error_code = ERR_CHECKSUM;
                        abort          = 1'b1;
                    end else begin
                        n_phase = PH_CR;
                    end
                end
                PH_CR: begin
                    if (i_byte == CH_CR) begin
                        n_phase = PH_LF;
                    end else begin
                        res.frame_end  = 1'b1;
                        res.error_code = ERR_NO_CR;
                        abort          = 1'b1;
                    end
                end
                PH_LF: begin
                    res.frame_end = 1'b1;
                    if (i_byte == CH_LF) begin
                        res.frame_good = 1'b1;
                    end else begin
                        res.error_code = ERR_NO_LF;
                    end
                    abort = 1'b1;
                end
                default: begin
                    abort = 1'b1;
                end
            endcase
        end

        if (abort) begin
            n_phase   = PH_IDLE;
            n_tag_pos = 3'd0;
            n_dcnt    = 4'd0;
            n_len     = 8'd0;
            n_xor     = 8'd0;
            n_hi      = 4'd0;
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tag_pos <= 3'd0;
            r_dcnt    <= 4'd0;
            r_len     <= 8'd0;
            r_xor     <= 8'd0;
            r_hi      <= 4'd0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_tag_pos <= n_tag_pos;
            r_dcnt    <= n_dcnt;
            r_len     <= n_len;
            r_xor     <= n_xor;
            r_hi      <= n_hi;
        end
    end

    `NSF_ASSERT_ALWAYS(a_len_bound, r_len <= MAX_LEN, "frame length past limit")
    `NSF_ASSERT_ALWAYS(a_idle_clean, r_phase != PH_IDLE || ~|{r_len, r_xor}, "idle not cleared")
    `NSF_ASSERT_ALWAYS(a_tag_pos_bound, r_tag_pos <= 3'd4, "tag position past tag")
    `NSF_ASSERT_NEXT(a_end_resets, i_fire && res.frame_end, r_phase <= PH_TAG, "end left busy")

endmodule

// File: hw/rtl/nsf_out_reg.sv
// Result register: holds one parsed result until the consumer takes it.
module nsf_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  nsf_pkg::t_result i_res,
    output logic             o_valid,
    input  logic             i_ready,
    output nsf_pkg::t_result o_res
);
    import nsf_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule
